// File: sv/olr_pkg.sv
`timescale 1ns / 1ps

package olr_pkg;

  localparam int unsigned MaxLineDefault = 256;
  localparam int unsigned EvqDepth       = 4;

  localparam logic [7:0] TermReset = 8'h0a;

  // frame tick positions, counted from the start edge
  localparam logic [5:0] BitTick0  = 6'd6;
  localparam logic [5:0] BitTick1  = 6'd10;
  localparam logic [5:0] BitTick2  = 6'd15;
  localparam logic [5:0] BitTick3  = 6'd19;
  localparam logic [5:0] BitTick4  = 6'd23;
  localparam logic [5:0] BitTick5  = 6'd27;
  localparam logic [5:0] BitTick6  = 6'd31;
  localparam logic [5:0] BitTick7  = 6'd35;
  localparam logic [5:0] PhaseDone = 6'd40;

  localparam logic ModeTick = 1'b0;
  localparam logic ModeArm  = 1'b1;
  localparam logic KindArm  = 1'b0;
  localparam logic KindByte = 1'b1;

  // event handed from the sampler side to line assembly
  typedef struct packed {
    logic       is_arm;
    logic [8:0] cap;
    logic [7:0] data;
  } evt_t;

  function automatic logic is_data_tick(input logic [5:0] p);
    return p inside {BitTick0, BitTick1, BitTick2, BitTick3,
                     BitTick4, BitTick5, BitTick6, BitTick7};
  endfunction

endpackage

// File: sv/olr_in_if.sv
`timescale 1ns / 1ps

interface olr_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic       rx_level;
  logic [8:0] arm_capacity;

  modport source (output valid, output mode, output rx_level, output arm_capacity,
                  input ready);
  modport sink   (input valid, input mode, input rx_level, input arm_capacity,
                  output ready);
endinterface

// File: sv/olr_out_if.sv
`timescale 1ns / 1ps

interface olr_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic       arm_busy;
  logic [7:0] rx_byte;
  logic       byte_stored;
  logic [7:0] store_index;
  logic       line_done;
  logic [7:0] line_length;

  modport source (output valid, output kind, output arm_busy, output rx_byte,
                  output byte_stored, output store_index, output line_done,
                  output line_length, input ready);
  modport sink   (input valid, input kind, input arm_busy, input rx_byte,
                  input byte_stored, input store_index, input line_done,
                  input line_length, output ready);
endinterface

// File: sv/oversampled_uart_line_receiver_core.sv
// Path: an item's result is held in the event queue and then in the registered result stage.
// Throughput: one item per cycle while the result side takes one per cycle; the
//   4-entry event queue between sampler and line assembly absorbs short stalls.
// Reset: rst_ni is asynchronous, active low; it idles the frame counter, disarms
//   the line, clears the queue and the result valid flag and sets the terminator to 0x0a.
`timescale 1ns / 1ps

module oversampled_uart_line_receiver_core #(
  parameter int unsigned MAX_LINE = olr_pkg::MaxLineDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  olr_in_if.sink     in_i,
  olr_out_if.source  out_o,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i
);

  // Terminator register. The user must write it only while the block is idle (the
  // block itself does not enforce this), so the line assembly side can read it directly.
  logic [7:0] term_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_q <= olr_pkg::TermReset;
    end else if (cfg_we_i) begin
      term_q <= cfg_wdata_i;
    end
  end

  // Front: frame counter and bit sampling. Every tick transfer is consumed
  // here; only arm requests and completed bytes travel on as events.
  olr_pkg::evt_t push_evt, head_evt;
  logic          push, pop, evq_full, evq_empty;

  olr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .evq_full_i (evq_full),
    .evt_push_o (push),
    .evt_o      (push_evt)
  );

  // Short event queue: lets the sampler keep taking ticks while the output
  // side is stalled.
  olr_evq u_evq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .evt_i   (push_evt),
    .pop_i   (pop),
    .full_o  (evq_full),
    .empty_o (evq_empty),
    .evt_o   (head_evt)
  );

  // Back: line assembly (arm state, line index, previous byte) and the
  // registered result stage.
  olr_back #(
    .MAX_LINE (MAX_LINE)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .evq_empty_i (evq_empty),
    .evt_i       (head_evt),
    .term_i      (term_q),
    .pop_o       (pop),
    .out_o       (out_o)
  );

endmodule

// File: sv/olr_front.sv
`timescale 1ns / 1ps

module olr_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  olr_in_if.sink        in_i,
  input  logic          evq_full_i,
  output logic          evt_push_o,
  output olr_pkg::evt_t evt_o
);

  logic       active_q, active_d;
  logic [5:0] phase_q, phase_d;
  logic [5:0] phase_inc;
  logic [7:0] shift_q, shift_d;
  logic       accept;

  assign in_i.ready = !evq_full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign phase_inc  = phase_q + 6'd1;

  always_comb begin
    active_d   = active_q;
    phase_d    = phase_q;
    shift_d    = shift_q;
    evt_push_o = 1'b0;
    evt_o      = '0;
    if (accept) begin
      if (in_i.mode == olr_pkg::ModeArm) begin
        evt_push_o   = 1'b1;
        evt_o.is_arm = 1'b1;
        evt_o.cap    = in_i.arm_capacity;
      end else if (!active_q) begin
        if (!in_i.rx_level) begin
          active_d = 1'b1;
          phase_d  = '0;
        end
      end else begin
        phase_d = phase_inc;
        if (olr_pkg::is_data_tick(phase_inc)) begin
          shift_d = {in_i.rx_level, shift_q[7:1]};
        end
        if (phase_inc == olr_pkg::PhaseDone) begin
          active_d   = 1'b0;
          evt_push_o = 1'b1;
          evt_o.data = shift_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      phase_q  <= '0;
      shift_q  <= '0;
    end else begin
      active_q <= active_d;
      phase_q  <= phase_d;
      shift_q  <= shift_d;
    end
  end

endmodule

// File: sv/olr_evq.sv
`timescale 1ns / 1ps

module olr_evq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  olr_pkg::evt_t evt_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          empty_o,
  output olr_pkg::evt_t evt_o
);

  localparam int unsigned Depth = olr_pkg::EvqDepth;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  olr_pkg::evt_t    mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign evt_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= evt_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// File: sv/olr_back.sv
`timescale 1ns / 1ps

module olr_back #(
  parameter int unsigned MAX_LINE = olr_pkg::MaxLineDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          evq_empty_i,
  input  olr_pkg::evt_t evt_i,
  input  logic [7:0]    term_i,
  output logic          pop_o,
  olr_out_if.source     out_o
);

  localparam int unsigned CapLimitInt = (MAX_LINE > 256) ? 256 : MAX_LINE;
  localparam logic [8:0]  CapLimit    = 9'(CapLimitInt);

  logic [8:0] armed_q, armed_d;
  logic [7:0] idx_q, idx_d;
  logic [7:0] prev_q, prev_d;
  logic       out_valid_q;

  logic       kind_d, busy_d, stored_d, done_d;
  logic [7:0] byte_d, sidx_d, len_d;
  logic [8:0] cap_clamp;

  logic       kind_q, busy_q, stored_q, done_q;
  logic [7:0] byte_q, sidx_q, len_q;

  assign pop_o     = !evq_empty_i && (!out_valid_q || out_o.ready);
  assign cap_clamp = (evt_i.cap > CapLimit) ? CapLimit : evt_i.cap;

  always_comb begin
    armed_d  = armed_q;
    idx_d    = idx_q;
    prev_d   = prev_q;
    kind_d   = olr_pkg::KindArm;
    busy_d   = 1'b0;
    byte_d   = '0;
    stored_d = 1'b0;
    sidx_d   = '0;
    done_d   = 1'b0;
    len_d    = '0;
    if (evt_i.is_arm) begin
      if (armed_q != '0) begin
        busy_d = 1'b1;
      end else begin
        idx_d   = '0;
        armed_d = cap_clamp;
      end
    end else begin
      kind_d = olr_pkg::KindByte;
      byte_d = evt_i.data;
      // store while the last slot stays free, once synced to a terminator or while a line is under way
      if ((({1'b0, idx_q} + 9'd1) < armed_q) && (prev_q == term_i || idx_q != '0)) begin
        stored_d = 1'b1;
        sidx_d   = idx_q;
        idx_d    = idx_q + 8'd1;
      end
      if (armed_q != '0 && evt_i.data == term_i) begin
        armed_d = '0;
        done_d  = 1'b1;
        len_d   = idx_d;
      end
      prev_d = evt_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q     <= '0;
      idx_q       <= '0;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        armed_q <= armed_d;
        idx_q   <= idx_d;
        prev_q  <= prev_d;
      end
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      kind_q   <= kind_d;
      busy_q   <= busy_d;
      byte_q   <= byte_d;
      stored_q <= stored_d;
      sidx_q   <= sidx_d;
      done_q   <= done_d;
      len_q    <= len_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.kind        = kind_q;
  assign out_o.arm_busy    = busy_q;
  assign out_o.rx_byte     = byte_q;
  assign out_o.byte_stored = stored_q;
  assign out_o.store_index = sidx_q;
  assign out_o.line_done   = done_q;
  assign out_o.line_length = len_q;

endmodule

// File: sv/olr_checker.sv
`timescale 1ns / 1ps

module olr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       kind_i,
  input logic       arm_busy_i,
  input logic [7:0] rx_byte_i,
  input logic       byte_stored_i,
  input logic [7:0] store_index_i,
  input logic       line_done_i,
  input logic [7:0] line_length_i
);

  a_arm_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && kind_i == olr_pkg::KindArm) |->
      (rx_byte_i == '0 && !byte_stored_i && !line_done_i))
    else $error("arm response carries byte fields");

  a_busy_arm_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && arm_busy_i) |-> (kind_i == olr_pkg::KindArm))
    else $error("busy flag on a byte result");

  a_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !byte_stored_i) |-> (store_index_i == '0))
    else $error("store index set without a store");

  a_length_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !line_done_i) |-> (line_length_i == '0))
    else $error("line length set without line completion");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(rx_byte_i)))
    else $error("stalled result dropped or changed");

endmodule

bind oversampled_uart_line_receiver_core olr_checker u_olr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .kind_i        (out_o.kind),
  .arm_busy_i    (out_o.arm_busy),
  .rx_byte_i     (out_o.rx_byte),
  .byte_stored_i (out_o.byte_stored),
  .store_index_i (out_o.store_index),
  .line_done_i   (out_o.line_done),
  .line_length_i (out_o.line_length)
);

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

  // Largest line capacity the block will keep, whatever the arm asks for.
  localparam int unsigned CapCeiling      =
      (olr_pkg::MaxLineDefault < 256) ? olr_pkg::MaxLineDefault : 256;
  // Margin on top of the event queue and the registered result stage.
  localparam int unsigned SettleCycles    = 8;
  // Upper bound on the run length; the watchdog fails the run past it.
  localparam int unsigned CycleLimit      = 20000;
  localparam int unsigned ShownMismatches = 10;
  localparam int unsigned GapPercent      = 16;

  typedef struct packed {
    logic       kind;
    logic       arm_busy;
    logic [7:0] rx_byte;
    logic       byte_stored;
    logic [7:0] store_index;
    logic       line_done;
    logic [7:0] line_length;
  } rx_report_t;

  // Tracks the receiver's frame counter and line assembly, and holds the
  // reports the block still owes us, oldest first.
  class line_scoreboard;
    logic [7:0] term_char;
    bit         in_frame;
    logic [5:0] tick_count;
    logic [7:0] shifter;
    logic [7:0] last_byte;
    logic [7:0] line_pos;
    logic [8:0] line_cap;
    rx_report_t awaited_reports[$];
    int unsigned failures;

    function new();
      term_char  = olr_pkg::TermReset;
      in_frame   = 1'b0;
      tick_count = '0;
      shifter    = '0;
      last_byte  = '0;
      line_pos   = '0;
      line_cap   = '0;
      failures   = 0;
    endfunction

    static function bit sample_tick(logic [5:0] p);
      case (p)
        olr_pkg::BitTick0, olr_pkg::BitTick1, olr_pkg::BitTick2, olr_pkg::BitTick3,
        olr_pkg::BitTick4, olr_pkg::BitTick5, olr_pkg::BitTick6,
        olr_pkg::BitTick7: return 1'b1;
        default: return 1'b0;
      endcase
    endfunction

    function void set_terminator(logic [7:0] value);
      term_char = value;
    endfunction

    function void take_item(logic mode, logic level, logic [8:0] cap);
      rx_report_t r;
      logic [7:0] b;
      r = '0;
      if (mode == olr_pkg::ModeArm) begin
        r.kind = olr_pkg::KindArm;
        if (line_cap != '0) begin
          r.arm_busy = 1'b1;       // line still pending, nothing changes
        end else begin
          line_pos = '0;
          line_cap = (cap > CapCeiling) ? 9'(CapCeiling) : cap;
        end
        awaited_reports.push_back(r);
        return;
      end
      if (!in_frame) begin
        if (level == 1'b0) begin
          in_frame   = 1'b1;
          tick_count = '0;
        end
        return;
      end
      tick_count = tick_count + 6'd1;
      if (sample_tick(tick_count))
        shifter = {level, shifter[7:1]};
      if (tick_count != olr_pkg::PhaseDone)
        return;
      in_frame  = 1'b0;
      b         = shifter;
      r.kind    = olr_pkg::KindByte;
      r.rx_byte = b;
      // store only once synced on a terminator, and keep the last slot free
      if ({1'b0, line_pos} + 9'd1 < line_cap && (last_byte == term_char || line_pos != '0)) begin
        r.byte_stored = 1'b1;
        r.store_index = line_pos;
        line_pos      = line_pos + 8'd1;
      end
      if (line_cap != '0 && b == term_char) begin
        line_cap      = '0;
        r.line_done   = 1'b1;
        r.line_length = line_pos;
      end
      last_byte = b;
      awaited_reports.push_back(r);
    endfunction

    function string describe(rx_report_t r);
      return $sformatf("kind=%0d busy=%0d byte=%02h stored=%0d idx=%0d done=%0d len=%0d",
                       r.kind, r.arm_busy, r.rx_byte, r.byte_stored, r.store_index,
                       r.line_done, r.line_length);
    endfunction

    function void check_report(rx_report_t got);
      rx_report_t want;
      if (awaited_reports.size() == 0) begin
        failures++;
        if (failures <= ShownMismatches)
          $display("unexpected result: %s", describe(got));
        return;
      end
      want = awaited_reports.pop_front();
      if (got.kind !== want.kind || got.arm_busy !== want.arm_busy ||
          got.rx_byte !== want.rx_byte || got.byte_stored !== want.byte_stored ||
          got.store_index !== want.store_index || got.line_done !== want.line_done ||
          got.line_length !== want.line_length) begin
        failures++;
        if (failures <= ShownMismatches)
          $display("mismatch: expected %s, got %s", describe(want), describe(got));
      end
    endfunction

    function void close_out();
      if (awaited_reports.size() != 0) begin
        failures++;
        $display("%0d results never arrived", awaited_reports.size());
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [7:0] cfg_wdata_i;

  olr_in_if  in_bus ();
  olr_out_if out_bus ();

  oversampled_uart_line_receiver_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_bus),
    .out_o       (out_bus),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  line_scoreboard line_sb = new();

  bit          no_gaps;            // both sides stop idling while set
  int unsigned hold_off_request;   // sink stall length, picked up by the sink process
  int unsigned bytes_sent;
  int unsigned cycle_count = 0;

  // 8 ns clock
  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // Watchdog: only a hung handshake gets here.
  initial begin
    wait (cycle_count >= CycleLimit);
    $display("Simulation FAILED");
    $finish;
  end

  // Result side: ready moves at the falling edge. Random gaps, except while
  // a hold-off is running or gaps are switched off.
  initial begin
    int unsigned hold_left;
    hold_left     = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_request != 0) begin
        hold_left        = hold_off_request;
        hold_off_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= no_gaps || ($urandom_range(99) >= GapPercent);
      end
    end
  end

  // Every result transfer is checked against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_bus.valid && out_bus.ready)
      line_sb.check_report('{kind: out_bus.kind, arm_busy: out_bus.arm_busy,
                             rx_byte: out_bus.rx_byte, byte_stored: out_bus.byte_stored,
                             store_index: out_bus.store_index, line_done: out_bus.line_done,
                             line_length: out_bus.line_length});
  end

  // One input transfer. Entered and left at a falling edge; valid stays up
  // on exit so back-to-back items do not toggle it.
  task automatic send_item(input logic mode, input logic level, input logic [8:0] cap);
    while (!no_gaps && $urandom_range(99) < GapPercent) begin
      in_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_bus.valid        <= 1'b1;
    in_bus.mode         <= mode;
    in_bus.rx_level     <= level;
    in_bus.arm_capacity <= cap;
    do @(posedge clk_i); while (!in_bus.ready);
    line_sb.take_item(mode, level, cap);
    @(negedge clk_i);
  endtask

  task automatic send_tick(input logic level);
    send_item(olr_pkg::ModeTick, level, 9'($urandom_range(511)));
  endtask

  task automatic send_arm(input logic [8:0] cap);
    send_item(olr_pkg::ModeArm, 1'($urandom_range(1)), cap);
  endtask

  // A full serial frame: up to two idle ticks, the start tick, then 40 ticks with
  // the data bits on the sample points and noise everywhere else. An arm can
  // be slipped in before tick arm_phase to land mid-frame.
  task automatic send_byte(input logic [7:0] value, input int unsigned arm_phase = 0,
                           input logic [8:0] arm_cap = '0);
    int unsigned slot;
    slot = 0;
    repeat ($urandom_range(2)) send_tick(1'b1);
    send_tick(1'b0);
    for (int unsigned p = 1; p <= olr_pkg::PhaseDone; p++) begin
      if (p == arm_phase)
        send_arm(arm_cap);
      if (line_scoreboard::sample_tick(6'(p))) begin
        send_tick(value[slot]);
        slot++;
      end else begin
        send_tick(1'($urandom_range(1)));
      end
    end
    bytes_sent++;
  endtask

  // Sync terminator, arm, payload, closing terminator. Payload mostly avoids
  // the terminator; strict keeps it out entirely.
  task automatic send_line(input int unsigned payload, input logic [8:0] cap, input bit strict);
    logic [7:0] v;
    send_byte(line_sb.term_char);
    send_arm(cap);
    for (int unsigned i = 0; i < payload; i++) begin
      v = 8'($urandom);
      if (v == line_sb.term_char && (strict || $urandom_range(19) != 0))
        v = v ^ 8'h01;
      if ($urandom_range(9) == 0)
        send_byte(v, $urandom_range(1, 40), 9'($urandom_range(511)));
      else
        send_byte(v);
      if ($urandom_range(19) == 0)
        send_arm(9'($urandom_range(511)));
    end
    send_byte(line_sb.term_char);
  endtask

  // Lower valid and wait for every owed result, plus margin for frames still
  // counting ticks inside the block.
  task automatic settle();
    in_bus.valid <= 1'b0;
    while (line_sb.awaited_reports.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_terminator(input logic [7:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    line_sb.set_terminator(value);
  endtask

  // Mostly short lines with random content and capacity; the rest is
  // lone bytes, stray arms and noise bursts followed by a quiet realignment.
  task automatic random_phase(input int unsigned byte_goal);
    int unsigned start;
    int unsigned pick;
    logic [8:0]  cap;
    start = bytes_sent;
    while (bytes_sent - start < byte_goal) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        cap = ($urandom_range(9) < 8) ? 9'($urandom_range(10)) : 9'($urandom_range(511));
        send_line($urandom_range(3), cap, 1'b0);
      end else if (pick < 75) begin
        send_byte(8'($urandom));
      end else if (pick < 85) begin
        send_arm(9'($urandom_range(511)));
      end else begin
        repeat ($urandom_range(1, 50))
          send_item(($urandom_range(9) == 0) ? olr_pkg::ModeArm : olr_pkg::ModeTick,
                    1'($urandom_range(1)), 9'($urandom_range(511)));
        repeat (int'(olr_pkg::PhaseDone) + 1) send_tick(1'b1);
      end
    end
  endtask

  initial begin
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_wdata_i         = '0;
    in_bus.valid        = 1'b0;
    in_bus.mode         = olr_pkg::ModeTick;
    in_bus.rx_level     = 1'b1;
    in_bus.arm_capacity = '0;
    no_gaps             = 1'b0;
    hold_off_request    = 0;
    bytes_sent          = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed, terminator at its reset value.
    send_byte(olr_pkg::TermReset);     // unarmed byte, still becomes the previous byte
    send_arm(9'd0);                    // capacity zero: accepted but stays unarmed
    send_arm(9'd3);
    send_arm(9'h1ff);                  // already pending -> busy
    send_byte(8'hff, 12, 9'h1ff);      // index 0, busy arm lands mid-frame
    send_byte(8'h55);                  // index 1
    send_byte(8'haa);                  // line full, not stored
    send_byte(olr_pkg::TermReset);     // terminator still closes the full line

    // Stretch without any idling on either side, new terminator.
    settle();
    write_terminator(8'h00);
    no_gaps = 1'b1;
    send_arm(9'h1ff);                  // oversize capacity gets clamped
    send_byte(8'h00);                  // not synced yet: closes an empty line
    send_byte(8'h81, 20, 9'd2);        // arm mid-frame while unarmed, frame undisturbed
    send_byte(8'h00);                  // closes a line of one byte
    no_gaps = 1'b0;

    // Sink holds off while arms keep coming: the block backs up and stalls input.
    settle();
    write_terminator(8'($urandom));
    hold_off_request = 120;
    repeat (24) send_arm(9'($urandom_range(511)));
    random_phase(3);

    settle();
    line_sb.close_out();
    if (line_sb.failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
sv/olr_pkg.sv
sv/olr_in_if.sv
sv/olr_out_if.sv
sv/olr_front.sv
sv/olr_evq.sv
sv/olr_back.sv
sv/oversampled_uart_line_receiver_core.sv
sv/olr_checker.sv
tb/testbench.sv
